@@ hdl/strip_peak_analyzer_defines.svh @@
// Assertion macros shared by the strip peak analyser RTL.
`ifndef STRIP_PEAK_ANALYZER_DEFINES_SVH
`define STRIP_PEAK_ANALYZER_DEFINES_SVH

// Checks a property on every rising edge of aclk while out of reset.
`define SPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/spa_pkg.sv @@
// Shared constants, types and state encodings of the strip peak analyser.
`default_nettype none
package spa_pkg;

    localparam int MAX_BINS  = 64;
    localparam int MAX_PEAKS = 32;

    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int BCNT_W   = $clog2(MAX_BINS + 1);
    localparam int NZ_W     = BIN_W + 1;
    localparam int SUM_W    = SAMPLE_W + BIN_W;
    localparam int PK_AW    = $clog2(MAX_PEAKS);
    localparam int PK_CW    = $clog2(MAX_PEAKS + 1);

    // Widths of the result fields on the ports.
    localparam int OUT_IDX_W = 6;
    localparam int OUT_SUM_W = 22;
    localparam int OUT_VB_W  = 7;
    localparam int OUT_NZ_W  = 7;
    localparam int OUT_CNT_W = 6;

    // Event queue between front and back.
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    // One queue entry: an optional maximum, and on the final beat the strip summary.
    typedef struct packed {
        logic                       peak_vld;
        logic [BIN_W-1:0]           peak_idx;
        logic signed [SAMPLE_W-1:0] peak_val;
        logic                       end_vld;
        logic                       head;
        logic                       tail_vld;
        logic [BIN_W-1:0]           tail_idx;
        logic signed [SAMPLE_W-1:0] tail_val;
        logic signed [SUM_W-1:0]    integral;
        logic [BCNT_W-1:0]          valid_bins;
        logic signed [NZ_W-1:0]     first_nz;
        logic signed [NZ_W-1:0]     last_nz;
    } spa_evt_t;

    // One stored maximum.
    typedef struct packed {
        logic [BIN_W-1:0]           idx;
        logic signed [SAMPLE_W-1:0] val;
    } spa_peak_t;

    typedef enum logic [2:0] {
        B_COLLECT,
        B_SCAN_RD,
        B_SCAN_USE,
        B_EMIT_RD,
        B_EMIT_USE,
        B_EMPTY
    } spa_bstate_t;

endpackage
`default_nettype wire

@@ hdl/spa_front.sv @@
// Front end: takes sample beats, keeps the strip statistics and detects local maxima.
`default_nettype none
`include "strip_peak_analyzer_defines.svh"
module spa_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [spa_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    input  logic                                q_full,
    output logic                                evt_push,
    output spa_pkg::spa_evt_t                   evt
);
    import spa_pkg::*;

    logic                       clamp_reg, clamp_next;
    logic [BCNT_W-1:0]          bin_reg, bin_upd, bin_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_upd, prev_next;
    logic                       asc_reg, asc_upd, asc_next;
    logic                       rise_reg, rise_upd, rise_next;
    logic                       head_reg, head_upd, head_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_upd, sum_next;
    logic [BCNT_W-1:0]          nzc_reg, nzc_upd, nzc_next;
    logic signed [NZ_W-1:0]     first_reg, first_upd, first_next;
    logic signed [NZ_W-1:0]     last_reg, last_upd, last_next;

    logic                       accept, work, not_first, second;
    logic                       rise, fall, head_hit, peak_hit;
    logic [BIN_W-1:0]           bin_lo;
    logic signed [SAMPLE_W-1:0] smp;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign work      = accept && (bin_reg < BCNT_W'(MAX_BINS));
    assign bin_lo    = bin_reg[BIN_W-1:0];
    assign not_first = (bin_reg != '0);
    assign second    = (bin_reg == BCNT_W'(1));
    assign smp       = (clamp_reg && s_sample[SAMPLE_W-1]) ? '0 : s_sample;
    assign rise      = (smp > prev_reg);
    assign fall      = (smp < prev_reg);
    assign head_hit  = work && second && fall;
    // A fall after an ascent closes an interior peak; bin 0 falling into bin 1 is the head peak.
    assign peak_hit  = work && not_first && fall && (second || asc_reg);

    always_comb begin
        bin_upd   = bin_reg;
        prev_upd  = prev_reg;
        asc_upd   = asc_reg;
        rise_upd  = rise_reg;
        head_upd  = head_reg;
        sum_upd   = sum_reg;
        nzc_upd   = nzc_reg;
        first_upd = first_reg;
        last_upd  = last_reg;
        if (work) begin
            bin_upd  = bin_reg + 1'b1;
            prev_upd = smp;
            sum_upd  = sum_reg + SUM_W'(smp);
            if (smp != '0) begin
                nzc_upd  = nzc_reg + 1'b1;
                last_upd = NZ_W'(bin_lo);
                if (first_reg[NZ_W-1]) begin
                    first_upd = NZ_W'(bin_lo);
                end
            end
            if (not_first) begin
                rise_upd = rise;
                if (rise) begin
                    asc_upd = 1'b1;
                end
                if (fall) begin
                    asc_upd = 1'b0;
                end
            end
            if (head_hit) begin
                head_upd = 1'b1;
            end
        end
    end

    always_comb begin
        clamp_next = cfg_wr_en ? cfg_wr_data : clamp_reg;
        if (accept && s_last) begin
            bin_next   = '0;
            prev_next  = '0;
            asc_next   = 1'b0;
            rise_next  = 1'b0;
            head_next  = 1'b0;
            sum_next   = '0;
            nzc_next   = '0;
            first_next = '1;
            last_next  = '1;
        end else begin
            bin_next   = bin_upd;
            prev_next  = prev_upd;
            asc_next   = asc_upd;
            rise_next  = rise_upd;
            head_next  = head_upd;
            sum_next   = sum_upd;
            nzc_next   = nzc_upd;
            first_next = first_upd;
            last_next  = last_upd;
        end
    end

    always_comb begin
        evt.peak_vld   = peak_hit;
        evt.peak_idx   = bin_lo - 1'b1;
        evt.peak_val   = prev_reg;
        evt.end_vld    = accept && s_last;
        evt.head       = head_upd;
        evt.tail_vld   = (bin_upd > BCNT_W'(1)) && rise_upd;
        evt.tail_idx   = BIN_W'(bin_upd - 1'b1);
        evt.tail_val   = prev_upd;
        evt.integral   = sum_upd;
        evt.valid_bins = nzc_upd;
        evt.first_nz   = first_upd;
        evt.last_nz    = last_upd;
    end

    assign evt_push = accept && (peak_hit || s_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_reg <= 1'b0;
            bin_reg   <= '0;
            prev_reg  <= '0;
            asc_reg   <= 1'b0;
            rise_reg  <= 1'b0;
            head_reg  <= 1'b0;
            sum_reg   <= '0;
            nzc_reg   <= '0;
            first_reg <= '1;
            last_reg  <= '1;
        end else begin
            clamp_reg <= clamp_next;
            bin_reg   <= bin_next;
            prev_reg  <= prev_next;
            asc_reg   <= asc_next;
            rise_reg  <= rise_next;
            head_reg  <= head_next;
            sum_reg   <= sum_next;
            nzc_reg   <= nzc_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    `SPA_ASSERT(a_bin_bound, bin_reg <= BCNT_W'(MAX_BINS), "bin index ran past the strip length")

endmodule
`default_nettype wire

@@ hdl/spa_queue.sv @@
// Short event queue that decouples the front end from the result sequencer.
`default_nettype none
`include "strip_peak_analyzer_defines.svh"
module spa_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  spa_pkg::spa_evt_t din,
    input  logic              pop,
    output spa_pkg::spa_evt_t dout,
    output logic              empty,
    output logic              full
);
    import spa_pkg::*;

    spa_evt_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (Q_AW + 1)'(Q_DEPTH));
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `SPA_ASSERT(a_q_fill, cnt_reg <= (Q_AW + 1)'(Q_DEPTH), "queue fill count exceeds its depth")

endmodule
`default_nettype wire

@@ hdl/spa_back.sv @@
// Back end: stores maxima, finds the global peak and sends out the result beats.
`default_nettype none
`include "strip_peak_analyzer_defines.svh"
module spa_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_empty,
    input  spa_pkg::spa_evt_t                    q_dout,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_has_maximum,
    output logic [spa_pkg::OUT_IDX_W-1:0]        m_peak_index,
    output logic signed [spa_pkg::SAMPLE_W-1:0]  m_peak_value,
    output logic                                 m_is_global,
    output logic signed [spa_pkg::OUT_SUM_W-1:0] m_integral,
    output logic [spa_pkg::OUT_VB_W-1:0]         m_valid_bins,
    output logic signed [spa_pkg::OUT_NZ_W-1:0]  m_first_nonzero,
    output logic signed [spa_pkg::OUT_NZ_W-1:0]  m_last_nonzero,
    output logic [spa_pkg::OUT_CNT_W-1:0]        m_maxima_count,
    output logic [spa_pkg::OUT_CNT_W-1:0]        m_global_count,
    output logic                                 m_last_result
);
    import spa_pkg::*;

    spa_bstate_t state_reg, state_next;
    logic [PK_CW-1:0] cnt_reg, cnt_next, cnt_new;
    logic [PK_CW-1:0] p_reg, p_next;
    logic [PK_CW-1:0] k_reg, k_new;
    logic [PK_CW:0]   k_sum;
    logic signed [SAMPLE_W-1:0] best_reg;
    logic [PK_CW-1:0] best_cnt_reg;

    // Strip summary held while the results go out.
    logic                       head_reg, tail_vld_reg;
    logic [BIN_W-1:0]           tail_idx_reg;
    logic signed [SAMPLE_W-1:0] tail_val_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [BCNT_W-1:0]          vb_reg;
    logic signed [NZ_W-1:0]     fnz_reg, lnz_reg;

    spa_peak_t        peak_mem [MAX_PEAKS];
    spa_peak_t        rd_data_reg;
    logic [PK_CW-1:0] rd_idx;
    logic             mem_we, end_pop, out_free, out_load, p_last, cur_is_tail;
    logic [BIN_W-1:0]           cur_idx;
    logic signed [SAMPLE_W-1:0] cur_val;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_has_max_reg, m_is_global_reg, m_last_result_reg;
    logic                       m_last_result_next;
    logic [OUT_IDX_W-1:0]       m_idx_reg;
    logic signed [SAMPLE_W-1:0] m_val_reg;
    logic signed [OUT_SUM_W-1:0] m_sum_reg;
    logic [OUT_VB_W-1:0]        m_vb_reg;
    logic signed [OUT_NZ_W-1:0] m_fnz_reg, m_lnz_reg;
    logic [OUT_CNT_W-1:0]       m_maxc_reg, m_globc_reg;

    // List order: head peak, then tail peak, then the stored interior peaks.
    assign cur_is_tail = tail_vld_reg && (p_reg == PK_CW'(head_reg));
    assign rd_idx      = (tail_vld_reg && (p_reg > PK_CW'(head_reg))) ? p_reg - 1'b1 : p_reg;
    assign cur_idx     = cur_is_tail ? tail_idx_reg : rd_data_reg.idx;
    assign cur_val     = cur_is_tail ? tail_val_reg : rd_data_reg.val;
    assign p_last      = (p_reg == k_reg - 1'b1);
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        q_pop    = (state_reg == B_COLLECT) && !q_empty;
        end_pop  = q_pop && q_dout.end_vld;
        mem_we   = q_pop && q_dout.peak_vld && (cnt_reg < PK_CW'(MAX_PEAKS));
        cnt_new  = mem_we ? cnt_reg + 1'b1 : cnt_reg;
        k_sum    = {1'b0, cnt_new} + (PK_CW + 1)'(q_dout.tail_vld);
        k_new    = (k_sum > (PK_CW + 1)'(MAX_PEAKS)) ? PK_CW'(MAX_PEAKS) : k_sum[PK_CW-1:0];
        out_load = out_free && ((state_reg == B_EMIT_USE) || (state_reg == B_EMPTY));
        m_last_result_next = (state_reg == B_EMPTY) || p_last;
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        p_next   = p_reg;
        cnt_next = cnt_new;
        case (state_reg)
            B_COLLECT: begin
                if (end_pop) begin
                    p_next = '0;
                end
            end
            B_SCAN_USE: begin
                p_next = p_last ? '0 : p_reg + 1'b1;
            end
            B_EMIT_USE: begin
                if (out_free) begin
                    p_next = p_last ? '0 : p_reg + 1'b1;
                    if (p_last) begin
                        cnt_next = '0;
                    end
                end
            end
            B_EMPTY: begin
                if (out_free) begin
                    cnt_next = '0;
                end
            end
            default: begin
                p_next = p_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_COLLECT: begin
                if (end_pop) begin
                    state_next = (k_new == '0) ? B_EMPTY : B_SCAN_RD;
                end
            end
            B_SCAN_RD:  state_next = B_SCAN_USE;
            B_SCAN_USE: state_next = p_last ? B_EMIT_RD : B_SCAN_RD;
            B_EMIT_RD:  state_next = B_EMIT_USE;
            B_EMIT_USE: begin
                if (out_free) begin
                    state_next = p_last ? B_COLLECT : B_EMIT_RD;
                end
            end
            B_EMPTY: begin
                if (out_free) begin
                    state_next = B_COLLECT;
                end
            end
            default: state_next = B_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            peak_mem[cnt_reg[PK_AW-1:0]] <= '{idx: q_dout.peak_idx, val: q_dout.peak_val};
        end
        rd_data_reg <= peak_mem[rd_idx[PK_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (end_pop) begin
            head_reg     <= q_dout.head;
            tail_vld_reg <= q_dout.tail_vld;
            tail_idx_reg <= q_dout.tail_idx;
            tail_val_reg <= q_dout.tail_val;
            sum_reg      <= q_dout.integral;
            vb_reg       <= q_dout.valid_bins;
            fnz_reg      <= q_dout.first_nz;
            lnz_reg      <= q_dout.last_nz;
            k_reg        <= k_new;
        end
        if (state_reg == B_SCAN_USE) begin
            if ((p_reg == '0) || (cur_val > best_reg)) begin
                best_reg     <= cur_val;
                best_cnt_reg <= PK_CW'(1);
            end else if (cur_val == best_reg) begin
                best_cnt_reg <= best_cnt_reg + 1'b1;
            end
        end
        if (out_load) begin
            m_sum_reg         <= OUT_SUM_W'(sum_reg);
            m_vb_reg          <= OUT_VB_W'(vb_reg);
            m_fnz_reg         <= OUT_NZ_W'(fnz_reg);
            m_lnz_reg         <= OUT_NZ_W'(lnz_reg);
            m_last_result_reg <= m_last_result_next;
            if (state_reg == B_EMPTY) begin
                m_has_max_reg   <= 1'b0;
                m_idx_reg       <= '0;
                m_val_reg       <= '0;
                m_is_global_reg <= 1'b0;
                m_maxc_reg      <= '0;
                m_globc_reg     <= '0;
            end else begin
                m_has_max_reg   <= 1'b1;
                m_idx_reg       <= OUT_IDX_W'(cur_idx);
                m_val_reg       <= cur_val;
                m_is_global_reg <= (cur_val == best_reg);
                m_maxc_reg      <= OUT_CNT_W'(k_reg);
                m_globc_reg     <= OUT_CNT_W'(best_cnt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_COLLECT;
            cnt_reg     <= '0;
            p_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            p_reg       <= p_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_has_maximum   = m_has_max_reg;
    assign m_peak_index    = m_idx_reg;
    assign m_peak_value    = m_val_reg;
    assign m_is_global     = m_is_global_reg;
    assign m_integral      = m_sum_reg;
    assign m_valid_bins    = m_vb_reg;
    assign m_first_nonzero = m_fnz_reg;
    assign m_last_nonzero  = m_lnz_reg;
    assign m_maxima_count  = m_maxc_reg;
    assign m_global_count  = m_globc_reg;
    assign m_last_result   = m_last_result_reg;

    `SPA_ASSERT(a_store_bound, cnt_reg <= PK_CW'(MAX_PEAKS), "peak store count exceeds its depth")
    `SPA_ASSERT(a_pos_range, ((state_reg == B_SCAN_USE) || (state_reg == B_EMIT_USE)) |-> (p_reg < k_reg), "list position outside the maxima list")
    `SPA_ASSERT_NEXT(a_strip_done, out_load && m_last_result_next, (state_reg == B_COLLECT) && (cnt_reg == '0), "sequencer did not return to collection after the final result")

endmodule
`default_nettype wire

@@ hdl/strip_peak_analyzer.sv @@
// Top level of the strip peak analyser: front end, event queue and result sequencer.
`default_nettype none
// The analyser takes one strip of signed time-bin samples, one sample per beat on the
// s_ channel with s_last on the final bin, and reports every local maximum of the strip
// on the m_ channel once the strip has ended. Each result beat carries the bin index and
// value of one maximum, whether that value equals the highest among all maxima, and the
// strip summary (integral, nonzero bin count, first and last nonzero bin, number of
// maxima and of global maxima); m_last_result marks the final beat of a strip. A strip
// without maxima gives a single summary beat with m_has_maximum low. Maxima go out as the
// head peak first, then the tail peak, then the interior peaks in bin order, at most
// MAX_PEAKS of them; bins past MAX_BINS are ignored, though their last flag still ends the
// strip. Setting cfg_wr_en writes the clamp flag from cfg_wr_data: when set, negative
// samples count as zero. The front end takes one sample beat per cycle and writes every
// maximum it finds, plus the strip summary, into a four-entry event queue; s_ready drops
// only while that queue is full. The back end stores the maxima in a 32-entry peak memory
// with a registered read port: at the end of a strip, the pass that finds the global
// peak and the output each use a read state and a use state per maximum, with the
// result register free to hold a beat while the next one is fetched. During that drain
// the front end keeps accepting the next strip until the queue fills.
module strip_peak_analyzer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [spa_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_has_maximum,
    output logic [spa_pkg::OUT_IDX_W-1:0]        m_peak_index,
    output logic signed [spa_pkg::SAMPLE_W-1:0]  m_peak_value,
    output logic                                 m_is_global,
    output logic signed [spa_pkg::OUT_SUM_W-1:0] m_integral,
    output logic [spa_pkg::OUT_VB_W-1:0]         m_valid_bins,
    output logic signed [spa_pkg::OUT_NZ_W-1:0]  m_first_nonzero,
    output logic signed [spa_pkg::OUT_NZ_W-1:0]  m_last_nonzero,
    output logic [spa_pkg::OUT_CNT_W-1:0]        m_maxima_count,
    output logic [spa_pkg::OUT_CNT_W-1:0]        m_global_count,
    output logic                                 m_last_result
);
    import spa_pkg::*;

    // Events flow from the front end through the queue to the back end.
    spa_evt_t front_evt;
    spa_evt_t queue_evt;
    logic     evt_push;
    logic     evt_pop;
    logic     queue_empty;
    logic     queue_full;

    // The front end classifies each sample beat and pushes maxima and the strip summary.
    spa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .q_full      (queue_full),
        .evt_push    (evt_push),
        .evt         (front_evt)
    );

    // The queue lets the front end run on while the back end drains a finished strip.
    spa_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (evt_push),
        .din     (front_evt),
        .pop     (evt_pop),
        .dout    (queue_evt),
        .empty   (queue_empty),
        .full    (queue_full)
    );

    // The back end collects maxima, finds the global peak and sends the result beats.
    spa_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (queue_empty),
        .q_dout          (queue_evt),
        .q_pop           (evt_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_has_maximum   (m_has_maximum),
        .m_peak_index    (m_peak_index),
        .m_peak_value    (m_peak_value),
        .m_is_global     (m_is_global),
        .m_integral      (m_integral),
        .m_valid_bins    (m_valid_bins),
        .m_first_nonzero (m_first_nonzero),
        .m_last_nonzero  (m_last_nonzero),
        .m_maxima_count  (m_maxima_count),
        .m_global_count  (m_global_count),
        .m_last_result   (m_last_result)
    );

endmodule
`default_nettype wire
